>>> design/smmh_pkg.sv
// Shared types and constants for the symmetric min-max heap unit.
// No dependencies; imported by smmh_core and symmetric_min_max_heap_unit.
package smmh_pkg;

	localparam int HEAP_SLOTS = 64;
	localparam int SLOT_W     = $clog2(HEAP_SLOTS);
	localparam int WIDE_W     = SLOT_W + 2;
	localparam int KEY_W      = 32;
	localparam int FUNC_W     = 2;
	localparam int STAT_W     = 2;
	localparam int OCC_W      = 6;

	localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DEL_MIN = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DEL_MAX = 2'd2;

	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [WIDE_W-1:0] wide_t;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic signed [KEY_W-1:0] value;
	} smmh_in_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] removed_value;
		logic [STAT_W-1:0]       status;
		logic [OCC_W-1:0]        occupancy;
	} smmh_out_t;

endpackage

>>> design/smmh_core.sv
// Heap sequencer: key store, registered read ports, one compare path per step.
// Depends on smmh_pkg.
module smmh_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  smmh_pkg::smmh_in_t  cmd,
	output logic               res_valid,
	input  logic               res_ready,
	output smmh_pkg::smmh_out_t res
);
	import smmh_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_INS_SIB = 8'b0000_0010,
		S_INS_UP  = 8'b0000_0100,
		S_DEL_LD  = 8'b0000_1000,
		S_SIB     = 8'b0001_0000,
		S_KID     = 8'b0010_0000,
		S_PUT     = 8'b0100_0000,
		S_FIN     = 8'b1000_0000
	} state_t;

	// left child of the grandparent: (slot / 4) * 2
	function automatic slot_t gp_left(input slot_t s);
		gp_left = {1'b0, s[SLOT_W-1:2], 1'b0};
	endfunction

	state_t                  state_q, state_d;
	slot_t                   cur_q, cur_d;
	slot_t                   last_q, last_d;
	logic                    is_max_q, is_max_d;
	logic signed [KEY_W-1:0] x_q, x_d;
	logic signed [KEY_W-1:0] removed_q, removed_d;
	logic [STAT_W-1:0]       status_q, status_d;

	logic signed [KEY_W-1:0] mem [HEAP_SLOTS];
	logic signed [KEY_W-1:0] rd0_q, rd1_q;
	logic                    we;
	slot_t                   wa, ra0, ra1;
	logic signed [KEY_W-1:0] wd;

	wide_t                   cur_w, last_w, sib_a, c_a, c2_a, pick_a;
	logic                    c2_ok, swap, pick, stop;
	logic signed [KEY_W-1:0] kid_m;
	slot_t                   nxt, ncur;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd0_q <= mem[ra0];
		rd1_q <= mem[ra1];
	end

	assign cur_w  = wide_t'(cur_q);
	assign last_w = wide_t'(last_q);

	// sibling and child slots of the current hole
	always_comb begin
		if (is_max_q) begin
			sib_a = cur_w - WIDE_W'(1);
			c_a   = ((cur_w << 1) - WIDE_W'(1) <= last_w) ? (cur_w << 1) - WIDE_W'(1)
			                                             : (cur_w << 1) - WIDE_W'(2);
			c2_a  = ((cur_w << 1) + WIDE_W'(1) <= last_w) ? (cur_w << 1) + WIDE_W'(1)
			                                             : (cur_w << 1);
		end else begin
			sib_a = cur_w + WIDE_W'(1);
			c_a   = cur_w << 1;
			c2_a  = (cur_w << 1) + WIDE_W'(2);
		end
		c2_ok = (c2_a <= last_w);
		if (is_max_q) begin
			swap = (x_q < rd0_q);
			pick = c2_ok && (rd1_q > rd0_q);
		end else begin
			swap = (sib_a <= last_w) && (x_q > rd0_q);
			pick = c2_ok && (rd1_q < rd0_q);
		end
		kid_m  = pick ? rd1_q : rd0_q;
		pick_a = pick ? c2_a : c_a;
		stop   = is_max_q ? (kid_m <= x_q) : (kid_m >= x_q);
	end

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		last_d    = last_q;
		is_max_d  = is_max_q;
		x_d       = x_q;
		removed_d = removed_q;
		status_d  = status_q;
		we        = 1'b0;
		wa        = cur_q;
		wd        = x_q;
		ra0       = '0;
		ra1       = '0;
		nxt       = last_q + SLOT_W'(1);
		ncur      = cur_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					removed_d = '0;
					status_d  = STAT_DONE;
					x_d       = cmd.value;
					is_max_d  = (cmd.func == FUNC_DEL_MAX);
					case (cmd.func)
						FUNC_INSERT: begin
							if (last_q == SLOT_W'(HEAP_SLOTS - 1)) begin
								status_d = STAT_FULL;
								state_d  = S_FIN;
							end else begin
								last_d = nxt;
								cur_d  = nxt;
								if (nxt[0]) begin
									ra0     = last_q;
									state_d = S_INS_SIB;
								end else if (nxt[SLOT_W-1:2] != '0) begin
									ra0     = gp_left(nxt);
									ra1     = gp_left(nxt) | SLOT_W'(1);
									state_d = S_INS_UP;
								end else begin
									state_d = S_PUT;
								end
							end
						end
						FUNC_DEL_MIN, FUNC_DEL_MAX: begin
							if (last_q < SLOT_W'(2)) begin
								status_d = STAT_EMPTY;
								state_d  = S_FIN;
							end else begin
								ra0     = last_q;
								ra1     = (cmd.func == FUNC_DEL_MAX && last_q != SLOT_W'(2))
								          ? SLOT_W'(3) : SLOT_W'(2);
								state_d = S_DEL_LD;
							end
						end
						default: begin
							state_d = S_FIN;
						end
					endcase
				end
			end
			S_INS_SIB: begin
				if (x_q < rd0_q) begin
					we   = 1'b1;
					wd   = rd0_q;
					ncur = cur_q - SLOT_W'(1);
				end
				cur_d = ncur;
				if (ncur[SLOT_W-1:2] != '0) begin
					ra0     = gp_left(ncur);
					ra1     = gp_left(ncur) | SLOT_W'(1);
					state_d = S_INS_UP;
				end else begin
					state_d = S_PUT;
				end
			end
			S_INS_UP: begin
				if (x_q < rd0_q || x_q > rd1_q) begin
					we = 1'b1;
					if (x_q < rd0_q) begin
						wd   = rd0_q;
						ncur = gp_left(cur_q);
					end else begin
						wd   = rd1_q;
						ncur = gp_left(cur_q) | SLOT_W'(1);
					end
					cur_d = ncur;
					if (ncur[SLOT_W-1:2] != '0) begin
						ra0     = gp_left(ncur);
						ra1     = gp_left(ncur) | SLOT_W'(1);
						state_d = S_INS_UP;
					end else begin
						state_d = S_PUT;
					end
				end else begin
					state_d = S_PUT;
				end
			end
			S_DEL_LD: begin
				last_d = last_q - SLOT_W'(1);
				if (last_q == SLOT_W'(2)) begin
					removed_d = rd0_q;
					state_d   = S_FIN;
				end else begin
					removed_d = rd1_q;
					x_d       = rd0_q;
					if (!is_max_q) begin
						cur_d   = SLOT_W'(2);
						ra0     = SLOT_W'(3);
						state_d = S_SIB;
					end else if (last_q == SLOT_W'(3)) begin
						// the last key was the maximum itself
						state_d = S_FIN;
					end else begin
						cur_d   = SLOT_W'(3);
						ra0     = SLOT_W'(2);
						state_d = S_SIB;
					end
				end
			end
			S_SIB: begin
				if (swap) begin
					we  = 1'b1;
					wa  = sib_a[SLOT_W-1:0];
					wd  = x_q;
					x_d = rd0_q;
				end
				ra0     = c_a[SLOT_W-1:0];
				ra1     = c2_a[SLOT_W-1:0];
				state_d = (c_a > last_w) ? S_PUT : S_KID;
			end
			S_KID: begin
				if (stop) begin
					state_d = S_PUT;
				end else begin
					we    = 1'b1;
					wd    = kid_m;
					ncur  = pick_a[SLOT_W-1:0];
					cur_d = ncur;
					if (!is_max_q) begin
						ra0     = ncur + SLOT_W'(1);
						state_d = S_SIB;
					end else if (!ncur[0]) begin
						// left leaf on the max side: no sibling to order, nothing below
						state_d = S_PUT;
					end else begin
						ra0     = ncur - SLOT_W'(1);
						state_d = S_SIB;
					end
				end
			end
			S_PUT: begin
				we      = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= SLOT_W'(1);
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q     <= cur_d;
		is_max_q  <= is_max_d;
		x_q       <= x_d;
		removed_q <= removed_d;
		status_q  <= status_d;
	end

	assign cmd_ready         = (state_q == S_IDLE);
	assign res_valid         = (state_q == S_FIN);
	assign res.removed_value = removed_q;
	assign res.status        = status_q;
	assign res.occupancy     = OCC_W'(last_q - SLOT_W'(1));

endmodule

>>> design/symmetric_min_max_heap_unit.sv
// Symmetric min-max heap unit: valid/ready ports and output word register.
// Depends on smmh_pkg and smmh_core.

// Double-ended priority queue of up to 62 signed 32-bit keys. Each input word is
// an insert, delete-min or delete-max and yields one output word with the removed
// key, a status and the key count. One word is in work at a time; the work runs
// on the single key store with two registered read ports and one write port.
// An insert walks up the heap from the new leaf and a delete walks down from the
// root pair; each result then moves into the output register. Words that find
// the heap empty or full, and words with the unused code, skip the walk. A new
// word is taken while the previous result still waits in the output register.
module symmetric_min_max_heap_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  smmh_pkg::smmh_in_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output smmh_pkg::smmh_out_t out_data
);
	import smmh_pkg::*;

	logic      res_valid, res_ready;
	smmh_out_t res;
	logic      out_valid_q;
	smmh_out_t out_q;

	smmh_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (in_valid),
		.cmd_ready (in_ready),
		.cmd       (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> tb/tb_top.sv
// Self-checking bench for symmetric_min_max_heap_unit: directed words, then random traffic.
// Depends on smmh_pkg and the heap unit RTL; holds its own heap predictor.
module tb_top;
	import smmh_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_WORDS  = 400;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE_CYCLE = 40;

	typedef struct {
		smmh_in_t  w;
		bit        typed;
		smmh_out_t want;
	} script_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	smmh_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	smmh_out_t out_data;

	symmetric_min_max_heap_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state: keys in slots 2..top_slot
	int          keys [HEAP_SLOTS];
	int          top_slot;
	smmh_out_t   pending [$];
	script_row_t script [$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int          tx_idle_pct;
	int          rx_idle_pct;
	bit          long_hold_req = 1'b0;
	smmh_out_t   head_w;

	function automatic void heap_push(int x);
		int cur;
		int lc;
		top_slot++;
		cur = top_slot;
		if ((cur % 2 == 1) && x < keys[cur-1]) begin
			keys[cur] = keys[cur-1];
			cur--;
		end
		while (cur >= 4) begin
			lc = (cur / 4) * 2;
			if (x < keys[lc]) begin
				keys[cur] = keys[lc];
				cur = lc;
			end else if (x > keys[lc+1]) begin
				keys[cur] = keys[lc+1];
				cur = lc + 1;
			end else begin
				break;
			end
		end
		keys[cur] = x;
	endfunction

	// hole at slot 2, sibling order repaired at each level
	function automatic void sift_low(int x);
		int cur;
		int c;
		int t;
		cur = 2;
		forever begin
			if (cur + 1 <= top_slot && x > keys[cur+1]) begin
				t = keys[cur+1];
				keys[cur+1] = x;
				x = t;
			end
			c = 2 * cur;
			if (c > top_slot)
				break;
			if (c + 2 <= top_slot && keys[c+2] < keys[c])
				c += 2;
			if (keys[c] >= x)
				break;
			keys[cur] = keys[c];
			cur = c;
		end
		keys[cur] = x;
	endfunction

	function automatic void sift_high(int x);
		int cur;
		int c;
		int c2;
		int t;
		cur = 3;
		forever begin
			if (cur % 2 == 0)
				break;
			if (x < keys[cur-1]) begin
				t = keys[cur-1];
				keys[cur-1] = x;
				x = t;
			end
			// right node may have only a left child, or a sibling with children
			c = (2 * cur - 1 <= top_slot) ? 2 * cur - 1 : 2 * cur - 2;
			if (c > top_slot)
				break;
			c2 = (2 * cur + 1 <= top_slot) ? 2 * cur + 1 : 2 * cur;
			if (c2 <= top_slot && keys[c2] > keys[c])
				c = c2;
			if (keys[c] <= x)
				break;
			keys[cur] = keys[c];
			cur = c;
		end
		keys[cur] = x;
	endfunction

	function automatic smmh_out_t heap_step(smmh_in_t w);
		smmh_out_t r;
		int        x;
		r = '0;
		r.status = STAT_DONE;
		case (w.func)
			FUNC_INSERT: begin
				if (top_slot >= HEAP_SLOTS - 1)
					r.status = STAT_FULL;
				else
					heap_push(w.value);
			end
			FUNC_DEL_MIN, FUNC_DEL_MAX: begin
				if (top_slot < 2) begin
					r.status = STAT_EMPTY;
				end else if (top_slot == 2) begin
					r.removed_value = keys[2];
					top_slot = 1;
				end else begin
					x = keys[top_slot];
					r.removed_value = (w.func == FUNC_DEL_MIN) ? keys[2] : keys[3];
					top_slot--;
					if (w.func == FUNC_DEL_MIN)
						sift_low(x);
					else if (top_slot >= 3)
						sift_high(x);
				end
			end
			default: ;
		endcase
		r.occupancy = OCC_W'(top_slot - 1);
		return r;
	endfunction

	function automatic void add_row(logic [FUNC_W-1:0] f, int v, bit t, int rv,
		logic [STAT_W-1:0] st, int oc);
		script_row_t row;
		row.w.func = f;
		row.w.value = v;
		row.typed = t;
		row.want.removed_value = rv;
		row.want.status = st;
		row.want.occupancy = OCC_W'(oc);
		script.push_back(row);
	endfunction

	function automatic int pick_key();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return int'($urandom);
			5, 6, 7:       return int'($urandom_range(0, 16)) - 8;
			8:             return 32'h7fffffff - int'($urandom_range(0, 3));
			default:       return 32'h80000000 + int'($urandom_range(0, 3));
		endcase
	endfunction

	// call right after a rising edge; predicts on acceptance
	task automatic send_word(smmh_in_t w, bit typed, smmh_out_t want);
		smmh_out_t pred;
		in_valid <= 1'b1;
		in_data <= w;
		do
			@(posedge clk);
		while (!in_ready);
		pred = heap_step(w);
		pending.push_back(typed ? want : pred);
	endtask

	task automatic pace_and_send(smmh_in_t w, bit typed, smmh_out_t want);
		int gap;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		send_word(w, typed, want);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		smmh_in_t  w;
		smmh_out_t none;
		int        mode;
		int        seg_len;
		int        n;
		int        pick;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		none = '0;
		top_slot = 1;
		foreach (keys[i])
			keys[i] = 0;
		tx_idle_pct = 10;
		rx_idle_pct = 60;

		// empty, unused code, single-key extremes, then a small heap
		add_row(FUNC_DEL_MIN, 0, 1, 0, STAT_EMPTY, 0);
		add_row(FUNC_DEL_MAX, 32'h7fffffff, 1, 0, STAT_EMPTY, 0);
		add_row(FUNC_UNUSED, -1, 1, 0, STAT_DONE, 0);
		add_row(FUNC_INSERT, 32'h7fffffff, 1, 0, STAT_DONE, 1);
		add_row(FUNC_DEL_MIN, 0, 1, 32'h7fffffff, STAT_DONE, 0);
		add_row(FUNC_INSERT, 32'h80000000, 1, 0, STAT_DONE, 1);
		add_row(FUNC_DEL_MAX, -1, 1, 32'h80000000, STAT_DONE, 0);
		add_row(FUNC_INSERT, -1, 1, 0, STAT_DONE, 1);
		add_row(FUNC_INSERT, 32'h80000000, 1, 0, STAT_DONE, 2);
		add_row(FUNC_INSERT, 32'h7fffffff, 1, 0, STAT_DONE, 3);
		add_row(FUNC_INSERT, 0, 1, 0, STAT_DONE, 4);
		add_row(FUNC_DEL_MIN, 0, 1, 32'h80000000, STAT_DONE, 3);
		add_row(FUNC_DEL_MAX, 0, 1, 32'h7fffffff, STAT_DONE, 2);
		add_row(FUNC_UNUSED, 5, 1, 0, STAT_DONE, 2);
		add_row(FUNC_INSERT, 5, 0, 0, STAT_DONE, 0);
		add_row(FUNC_INSERT, 5, 0, 0, STAT_DONE, 0);
		add_row(FUNC_INSERT, -7, 0, 0, STAT_DONE, 0);
		add_row(FUNC_INSERT, 100, 0, 0, STAT_DONE, 0);
		add_row(FUNC_INSERT, 32'h55555555, 0, 0, STAT_DONE, 0);
		add_row(FUNC_INSERT, 32'haaaaaaaa, 0, 0, STAT_DONE, 0);
		add_row(FUNC_DEL_MAX, 0, 0, 0, STAT_DONE, 0);
		add_row(FUNC_DEL_MIN, 0, 0, 0, STAT_DONE, 0);
		add_row(FUNC_DEL_MAX, 0, 0, 0, STAT_DONE, 0);
		add_row(FUNC_DEL_MIN, 0, 0, 0, STAT_DONE, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			pace_and_send(script[i].w, script[i].typed, script[i].want);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 60 : 0;
			rx_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 10 : 0;
			if (ph == 2)
				long_hold_req = 1'b1;
			n = 0;
			while (n < PHASE_WORDS) begin
				// fill, drain, insert-heavy, delete-heavy, balanced
				mode = $urandom_range(0, 4);
				seg_len = (mode < 2) ? $urandom_range(64, 75) : $urandom_range(20, 60);
				for (int k = 0; k < seg_len && n < PHASE_WORDS; k++) begin
					pick = $urandom_range(0, 99);
					w.value = pick_key();
					if (pick == 0)
						w.func = FUNC_UNUSED;
					else if ((mode == 0) || (mode == 2 && pick < 85) || (mode == 4 && pick < 50))
						w.func = FUNC_INSERT;
					else if ((mode == 3 && pick < 20) || (mode == 1 && pick < 2))
						w.func = FUNC_INSERT;
					else
						w.func = pick[0] ? FUNC_DEL_MIN : FUNC_DEL_MAX;
					pace_and_send(w, 1'b0, none);
					n++;
				end
			end
			drain();
		end

		repeat (SETTLE_CYCLE) @(posedge clk);
		if (mismatches == 0)
			$display("symmetric_min_max_heap_unit regression: pass");
		else
			$display("symmetric_min_max_heap_unit regression: fail");
		$finish;
	end

	// result side: random stalls plus one long hold-off to back up the unit
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending.size() == 0) begin
				$display("%0t: result word with none outstanding: %h", $time, out_data);
				mismatches++;
			end else begin
				head_w = pending.pop_front();
				if (out_data.removed_value !== head_w.removed_value) begin
					$display("%0t: removed_value expected %0d got %0d", $time,
						head_w.removed_value, out_data.removed_value);
					mismatches++;
				end
				if (out_data.status !== head_w.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						head_w.status, out_data.status);
					mismatches++;
				end
				if (out_data.occupancy !== head_w.occupancy) begin
					$display("%0t: occupancy expected %0d got %0d", $time,
						head_w.occupancy, out_data.occupancy);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d words outstanding", $time, pending.size());
			$display("symmetric_min_max_heap_unit regression: fail");
			$finish;
		end
	end

endmodule

>>> sim.f
design/smmh_pkg.sv
design/smmh_core.sv
design/symmetric_min_max_heap_unit.sv
tb/tb_top.sv
